// File: rtl/core/acos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acos_pkg;

    localparam int COMP_W      = 32;
    localparam int SQUARE_W    = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 17;
    localparam int UNIT_W      = 18;
    localparam int COS_W       = 17;
    localparam int NUM_W       = 50;
    localparam int DEN_W       = 33;
    localparam int PROD_W      = 36;
    localparam int DOT_W       = 37;

    localparam logic [COS_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [DOT_W-1:0] ROUND_HALF = 37'd32768;

    typedef logic [COMP_W-1:0]        mag_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic [COS_W-1:0]         cos_t;

    typedef struct packed {
        mag_t [5:0]  mag;
        logic [5:0]  neg;
    } side_t;

    typedef struct packed {
        cos_t        cosine;
        unit_t [2:0] u2;
        unit_t [2:0] u1;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/abs_cos_angle_two_vectors_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Normalizes two signed Q15.16 3D vectors and returns both unit vectors (signed
// Q1.16, zero for a zero vector) together with the absolute cosine of their angle
// (unsigned Q1.16, capped at 65536). One beat is accepted every cycle while the
// output keeps up. A beat passes through three input stages (sign split,
// squares, sums), the 32-stage square root pipeline, one root bit per stage, the
// six divider lanes of 19 stages (17 quotient stages, one bit each, plus an input
// and an output register), two merge stages and then the output register. A skid
// register on the output catches the beat that arrives while the output is
// stalled; the input then waits until that beat has moved on.
module abs_cos_angle_two_vectors_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // unit_first_x/y/z, unit_second_x/y/z, abs_cosine, zero pad
    output logic [127:0]      m_tdata
);

    localparam int SIDE_LAT = acos_pkg::SQRT_STAGES + 2;
    localparam int LAT      = 3 + acos_pkg::SQRT_STAGES + acos_pkg::DIV_STAGES + 2 + 2;

    logic en;

    logic [LAT-1:0]  valid_pipe_reg;
    acos_pkg::side_t side_reg [0:SIDE_LAT];
    logic [63:0]     sq_reg   [0:5];
    logic [63:0]     sum_reg  [0:1];
    logic [31:0]     norm     [0:1];

    acos_pkg::unit_t [2:0] u1;
    acos_pkg::unit_t [2:0] u2;
    acos_pkg::result_t     pipe_res;

    acos_pkg::result_t out_reg;
    acos_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // split into sign and magnitude
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                side_reg[0].neg[i] <= s_tdata[32*i+31];
                side_reg[0].mag[i] <= s_tdata[32*i+31] ? 32'(~s_tdata[32*i +: 32] + 32'd1)
                                                       : s_tdata[32*i +: 32];
            end
            for (int k = 1; k <= SIDE_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int i = 0; i < 6; i++) begin
                sq_reg[i] <= 64'(side_reg[0].mag[i]) * 64'(side_reg[0].mag[i]);
            end
            sum_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_reg[1] <= sq_reg[3] + sq_reg[4] + sq_reg[5];
        end
    end

    for (genvar v = 0; v < 2; v++) begin : g_norm
        acos_sqrt u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .s_in     (sum_reg[v]),
            .root_out (norm[v])
        );
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
        acos_pkg::unit_t lane_unit;
        acos_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .mag_in   (side_reg[SIDE_LAT].mag[l]),
            .neg_in   (side_reg[SIDE_LAT].neg[l]),
            .norm_in  (norm[l / 3]),
            .unit_out (lane_unit)
        );
        if (l < 3) begin : g_first
            assign u1[l] = lane_unit;
        end else begin : g_second
            assign u2[l-3] = lane_unit;
        end
    end

    acos_merge u_merge (
        .aclk    (aclk),
        .en      (en),
        .u1_in   (u1),
        .u2_in   (u2),
        .res_out (pipe_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_pipe_reg <= '0;
        end else if (en) begin
            valid_pipe_reg <= {valid_pipe_reg[LAT-2:0], s_tvalid};
        end
    end

    // output register with skid beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (valid_pipe_reg[LAT-1]) begin
                if (!out_valid_reg || m_tready) begin
                    out_reg       <= pipe_res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= pipe_res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.cosine, out_reg.u2, out_reg.u1};

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without output beat");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> !skid_valid_reg && out_valid_reg)
        else $error("skid beat not moved to output");

    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.cosine <= acos_pkg::ONE_Q16))
        else $error("cosine above one");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(out_reg))
        else $error("output beat changed while stalled");

endmodule

`default_nettype wire

// File: rtl/core/acos_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module acos_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [acos_pkg::SQUARE_W-1:0] s_in,
    output logic      [acos_pkg::ROOT_W-1:0]   root_out
);

    localparam int SQ = acos_pkg::SQRT_STAGES;

    logic [33:0] rem_reg  [0:SQ-2];
    logic [33:0] rem_next [0:SQ-2];
    logic [63:0] sv_reg   [0:SQ-2];
    logic [63:0] sv_next  [0:SQ-2];
    logic [31:0] root_reg  [0:SQ-1];
    logic [31:0] root_next [0:SQ-1];

    // one root bit per stage, two radicand bits shifted in each time
    always_comb begin
        logic [33:0] rp;
        logic [31:0] qp;
        logic [63:0] sp;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        for (int k = 0; k < SQ; k++) begin
            if (k == 0) begin
                rp = '0;
                qp = '0;
                sp = s_in;
            end else begin
                rp = rem_reg[k-1];
                qp = root_reg[k-1];
                sp = sv_reg[k-1];
            end
            rem_sh = {rp, sp[63:62]};
            trial  = {2'b00, qp, 2'b01};
            if (rem_sh >= trial) begin
                root_next[k] = {qp[30:0], 1'b1};
                if (k < SQ - 1) begin
                    rem_next[k] = 34'(rem_sh - trial);
                end
            end else begin
                root_next[k] = {qp[30:0], 1'b0};
                if (k < SQ - 1) begin
                    rem_next[k] = rem_sh[33:0];
                end
            end
            if (k < SQ - 1) begin
                sv_next[k] = {sp[61:0], 2'b00};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ; k++) begin
                root_reg[k] <= root_next[k];
            end
            for (int k = 0; k < SQ - 1; k++) begin
                rem_reg[k] <= rem_next[k];
                sv_reg[k]  <= sv_next[k];
            end
        end
    end

    assign root_out = root_reg[SQ-1];

endmodule

`default_nettype wire

// File: rtl/core/acos_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module acos_lane (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire acos_pkg::mag_t              mag_in,
    input  wire logic                        neg_in,
    input  wire logic [acos_pkg::ROOT_W-1:0] norm_in,
    output acos_pkg::unit_t                  unit_out
);

    localparam int DS = acos_pkg::DIV_STAGES;
    localparam int NW = acos_pkg::NUM_W;
    localparam int DW = acos_pkg::DEN_W;

    logic [NW-1:0] num0_reg;
    logic [DW-1:0] den0_reg;
    logic          neg0_reg;
    logic          zero0_reg;

    logic [NW-1:0] rem_reg  [0:DS-2];
    logic [NW-1:0] rem_next [0:DS-2];
    logic [DW-1:0] den_reg  [0:DS-2];
    logic [16:0]   q_reg    [0:DS-1];
    logic [16:0]   q_next   [0:DS-1];
    logic          neg_reg  [0:DS-1];
    logic          zero_reg [0:DS-1];

    acos_pkg::unit_t unit_reg;

    // quotient of (mag * 2^17 + n) / (2n), one bit per stage, msb first
    always_comb begin
        logic [NW-1:0] rp;
        logic [DW-1:0] dp;
        logic [16:0]   qp;
        logic [NW-1:0] dsh;
        for (int j = 0; j < DS; j++) begin
            if (j == 0) begin
                rp = num0_reg;
                dp = den0_reg;
                qp = '0;
            end else begin
                rp = rem_reg[j-1];
                dp = den_reg[j-1];
                qp = q_reg[j-1];
            end
            dsh = NW'(dp) << (DS - 1 - j);
            if (rp >= dsh) begin
                q_next[j] = {qp[15:0], 1'b1};
                if (j < DS - 1) begin
                    rem_next[j] = rp - dsh;
                end
            end else begin
                q_next[j] = {qp[15:0], 1'b0};
                if (j < DS - 1) begin
                    rem_next[j] = rp;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num0_reg  <= {1'b0, mag_in, 17'd0} + NW'(norm_in);
            den0_reg  <= {norm_in, 1'b0};
            neg0_reg  <= neg_in;
            zero0_reg <= (norm_in == '0);
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= zero0_reg;
            den_reg[0]  <= den0_reg;
            for (int j = 0; j < DS; j++) begin
                q_reg[j] <= q_next[j];
            end
            for (int j = 1; j < DS; j++) begin
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
            for (int j = 0; j < DS - 1; j++) begin
                rem_reg[j] <= rem_next[j];
            end
            for (int j = 1; j < DS - 1; j++) begin
                den_reg[j] <= den_reg[j-1];
            end
            if (zero_reg[DS-1]) begin
                unit_reg <= '0;
            end else if (neg_reg[DS-1]) begin
                unit_reg <= -$signed({1'b0, q_reg[DS-1]});
            end else begin
                unit_reg <= $signed({1'b0, q_reg[DS-1]});
            end
        end
    end

    assign unit_out = unit_reg;

endmodule

`default_nettype wire

// File: rtl/core/acos_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module acos_merge (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire acos_pkg::unit_t [2:0]  u1_in,
    input  wire acos_pkg::unit_t [2:0]  u2_in,
    output acos_pkg::result_t           res_out
);

    localparam int PW = acos_pkg::PROD_W;
    localparam int DW = acos_pkg::DOT_W;

    logic signed [PW-1:0] prod_reg [0:2];
    acos_pkg::unit_t [2:0] u1_reg;
    acos_pkg::unit_t [2:0] u2_reg;
    acos_pkg::result_t     res_reg;

    logic signed [DW-1:0] dot;
    logic [DW-1:0]        dot_mag;
    logic [DW-1:0]        rounded;
    logic [20:0]          cos_wide;

    always_comb begin
        dot      = DW'(prod_reg[0]) + DW'(prod_reg[1]) + DW'(prod_reg[2]);
        dot_mag  = dot[DW-1] ? DW'(-dot) : DW'(dot);
        rounded  = dot_mag + acos_pkg::ROUND_HALF;
        cos_wide = rounded[36:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= $signed(u1_in[i]) * $signed(u2_in[i]);
            end
            u1_reg     <= u1_in;
            u2_reg     <= u2_in;
            res_reg.u1 <= u1_reg;
            res_reg.u2 <= u2_reg;
            if (cos_wide > 21'(acos_pkg::ONE_Q16)) begin
                res_reg.cosine <= acos_pkg::ONE_Q16;
            end else begin
                res_reg.cosine <= cos_wide[16:0];
            end
        end
    end

    assign res_out = res_reg;

endmodule

`default_nettype wire
